FILE: hw/rtl/range_sum_point_add_tree_top_defines.svh
// ----------------------------------------------------------------------------
// Range sum tree assertion macros
// Shared assertion forms for the range sum tree.
// ----------------------------------------------------------------------------
`ifndef RANGE_SUM_POINT_ADD_TREE_TOP_DEFINES_SVH
`define RANGE_SUM_POINT_ADD_TREE_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define RSAT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RSAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/rsat_pkg.sv
// ----------------------------------------------------------------------------
// Range sum tree package
// Widths, defaults and the command record passed from front to back.
// ----------------------------------------------------------------------------
package rsat_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int LEN_W      = 11;
  localparam int POS_W      = 10;
  localparam int VAL_W      = 64;
  localparam int DATA_W     = 96;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             op;
    logic             err;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] lft;
    logic [LEN_W-1:0] rgt;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic busy;
  } back_stat_t;

endpackage

FILE: hw/rtl/rsat_front.sv
// ----------------------------------------------------------------------------
// Range sum tree front end
// Holds the length register, accepts transactions and checks their bounds.
// ----------------------------------------------------------------------------
module rsat_front #(
  parameter int Leaves = rsat_pkg::LEAVES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [rsat_pkg::LEN_W-1:0] cfg_wdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [rsat_pkg::DATA_W-1:0] s_tdata,
  input  logic                     s_tuser,
  input  logic                     q_full,
  input  rsat_pkg::back_stat_t     back_stat,
  output logic                     push,
  output rsat_pkg::cmd_t           push_cmd
);

  logic [rsat_pkg::LEN_W-1:0] used_length;
  logic [rsat_pkg::LEN_W-1:0] used_length_next;

  always_comb begin
    if (cfg_wdata == '0) begin
      used_length_next = rsat_pkg::LEN_W'(1);
    end else if (32'(cfg_wdata) > Leaves) begin
      used_length_next = rsat_pkg::LEN_W'(Leaves);
    end else begin
      used_length_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_length <= rsat_pkg::LEN_W'(Leaves > 1024 ? 1024 : Leaves);
    end else if (cfg_we) begin
      used_length <= used_length_next;
    end
  end

  assign s_tready = !q_full && back_stat.init_done;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_cmd.op  = s_tuser;
    push_cmd.pos = s_tdata[9:0];
    push_cmd.val = s_tdata[73:10];
    push_cmd.lft = s_tdata[83:74];
    push_cmd.rgt = s_tdata[94:84];
    if (s_tuser == rsat_pkg::OP_ADD) begin
      push_cmd.err = {1'b0, s_tdata[9:0]} >= used_length;
    end else begin
      push_cmd.err = ({1'b0, s_tdata[83:74]} >= s_tdata[94:84]) ||
                     (s_tdata[94:84] > used_length);
    end
  end

endmodule

FILE: hw/rtl/rsat_queue.sv
// ----------------------------------------------------------------------------
// Range sum tree command queue
// Two-entry queue between the front end and the tree engine.
// ----------------------------------------------------------------------------
module rsat_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsat_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           cmd_valid,
  output rsat_pkg::cmd_t cmd
);

  rsat_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign cmd_valid = count != 2'd0;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hw/rtl/rsat_back.sv
// ----------------------------------------------------------------------------
// Range sum tree engine
// Walks the node memory for adds and queries and registers each result.
// ----------------------------------------------------------------------------
module rsat_back #(
  parameter int Leaves = rsat_pkg::LEAVES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  rsat_pkg::cmd_t            cmd,
  output logic                      pop,
  output rsat_pkg::back_stat_t      back_stat,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rsat_pkg::VAL_W-1:0] m_tdata,
  output logic                      m_tuser
);

  localparam int NW = $clog2(2 * Leaves);
  localparam int KW = NW + 1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_ADD_RD = 8'b0000_0100,
    S_ADD_WR = 8'b0000_1000,
    S_Q_CHK  = 8'b0001_0000,
    S_Q_A    = 8'b0010_0000,
    S_Q_B    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [rsat_pkg::VAL_W-1:0] node_mem [2 * Leaves];
  logic [rsat_pkg::VAL_W-1:0] rd_data;
  logic [rsat_pkg::VAL_W-1:0] wr_data;
  logic [NW-1:0]              rd_addr;
  logic [NW-1:0]              wr_addr;
  logic                       rd_en;
  logic                       wr_en;

  logic [NW-1:0]              clr_idx;
  logic [KW-1:0]              k;
  logic [KW-1:0]              b;
  logic [KW-1:0]              bm1;
  logic [KW-1:0]              kp1;
  logic [rsat_pkg::VAL_W-1:0] val;
  logic [rsat_pkg::VAL_W-1:0] acc;
  logic                       stat;

  assign bm1 = b - KW'(1);
  assign kp1 = k + KW'(1);
  assign pop = (state == S_IDLE) && cmd_valid;
  assign back_stat.init_done = state != S_CLEAR;
  assign back_stat.busy      = state != S_IDLE;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k[NW-1:0];
    wr_en   = 1'b0;
    wr_addr = k[NW-1:0];
    wr_data = rd_data + val;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      S_ADD_RD: begin
        rd_en = 1'b1;
      end
      S_ADD_WR: begin
        wr_en = 1'b1;
      end
      S_Q_CHK: begin
        if (k < b && k[0]) begin
          rd_en = 1'b1;
        end else if (k < b && b[0]) begin
          rd_en   = 1'b1;
          rd_addr = bm1[NW-1:0];
        end
      end
      S_Q_A: begin
        if (b[0]) begin
          rd_en   = 1'b1;
          rd_addr = bm1[NW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= node_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == NW'(2 * Leaves - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            val  <= cmd.val;
            acc  <= '0;
            stat <= cmd.err;
            k    <= KW'(Leaves) + KW'(cmd.op == rsat_pkg::OP_QUERY ? cmd.lft : cmd.pos);
            b    <= KW'(Leaves) + KW'(cmd.rgt);
            if (cmd.err) begin
              state <= S_DONE;
            end else if (cmd.op == rsat_pkg::OP_QUERY) begin
              state <= S_Q_CHK;
            end else begin
              state <= S_ADD_RD;
            end
          end
        end
        S_ADD_RD: begin
          state <= S_ADD_WR;
        end
        S_ADD_WR: begin
          k <= k >> 1;
          state <= ((k >> 1) == '0) ? S_DONE : S_ADD_RD;
        end
        S_Q_CHK: begin
          if (k < b) begin
            if (k[0]) begin
              state <= S_Q_A;
            end else if (b[0]) begin
              b     <= bm1;
              state <= S_Q_B;
            end else begin
              k <= k >> 1;
              b <= b >> 1;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_Q_A: begin
          acc <= acc + rd_data;
          if (b[0]) begin
            k     <= kp1;
            b     <= bm1;
            state <= S_Q_B;
          end else begin
            k     <= kp1 >> 1;
            b     <= b >> 1;
            state <= S_Q_CHK;
          end
        end
        S_Q_B: begin
          acc   <= acc + rd_data;
          k     <= k >> 1;
          b     <= b >> 1;
          state <= S_Q_CHK;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= stat ? '0 : acc;
      m_tuser <= stat;
    end
  end

endmodule

FILE: hw/rtl/range_sum_point_add_tree_top.sv
// ----------------------------------------------------------------------------
// Range sum tree top level
// Point-add and range-sum tree over signed 64-bit elements.
// ----------------------------------------------------------------------------
// After reset all 2*Leaves words of the node memory are cleared, during which
// s_tready stays low. Each transaction then gives one result. An add reads and
// then writes one node per tree level, and a query reads up to two nodes per
// level, both walking the node memory through its read and write ports. A
// two-entry queue lets the next transactions be accepted while the engine
// works, and a finished result waits in the output register.
module range_sum_point_add_tree_top #(
  parameter int Leaves = rsat_pkg::LEAVES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rsat_pkg::LEN_W-1:0]  cfg_wdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // position[9:0], value[73:10], left_bound[83:74], right_bound[94:84], zero[95]
  input  logic [rsat_pkg::DATA_W-1:0] s_tdata,
  // op[0]
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // range_sum[63:0]
  output logic [rsat_pkg::VAL_W-1:0]  m_tdata,
  // status[0]
  output logic                        m_tuser
);

  `include "range_sum_point_add_tree_top_defines.svh"

  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 cmd_valid;
  rsat_pkg::cmd_t       push_cmd;
  rsat_pkg::cmd_t       cmd;
  rsat_pkg::back_stat_t back_stat;

  rsat_front #(.Leaves(Leaves)) u_front (
    .clk, .rst, .cfg_we, .cfg_wdata, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_full, .back_stat, .push, .push_cmd
  );

  rsat_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full(q_full), .pop, .cmd_valid, .cmd
  );

  rsat_back #(.Leaves(Leaves)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .pop, .back_stat, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser
  );

  `RSAT_ASSERT_NOW(a_no_accept_in_clear, clk, rst, !back_stat.init_done, !s_tready, "accept during clear")
  `RSAT_ASSERT_NOW(a_no_result_in_clear, clk, rst, !back_stat.init_done, !m_tvalid, "result during clear")
  `RSAT_ASSERT_NOW(a_error_sum_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0, "nonzero sum on error")
  `RSAT_ASSERT_NEXT(a_pop_starts_work, clk, rst, pop, back_stat.busy, "engine idle after pop")

endmodule
